FILE: design/prle_pkg.sv
// Shared types, constants and helpers for the pixel run-length encoder.
package prle_pkg;

  localparam int VALUE_W   = 16;
  localparam int LENGTH_W  = 25;
  localparam int COUNT_W   = 24;
  localparam int SIDE_W    = 13;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;

  localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(4096);

  localparam int PRLE_QUEUE_DEPTH = 4;

  // register index codes (byte address bit 2)
  localparam logic REG_ROW_TOTAL    = 1'b0;
  localparam logic REG_COLUMN_TOTAL = 1'b1;

  typedef struct packed {
    logic [LENGTH_W-1:0] length;
    logic [VALUE_W-1:0]  value;
  } run_t;

  // one queue entry: up to two runs caused by one pixel
  typedef struct packed {
    logic flush;     // previous run closed by a new value
    run_t prev;
    logic closing;   // pixel ends the frame
    run_t last;
  } cmd_t;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    if (v == '0) begin
      r = SIDE_W'(1);
    end else if (v > SIDE_MAX) begin
      r = SIDE_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [LENGTH_W-1:0] frame_product(input logic [SIDE_W-1:0] a,
                                                        input logic [SIDE_W-1:0] b);
    logic [LENGTH_W-1:0] ea;
    logic [LENGTH_W-1:0] eb;
    ea = {{(LENGTH_W-SIDE_W){1'b0}}, clamp_side(a)};
    eb = {{(LENGTH_W-SIDE_W){1'b0}}, clamp_side(b)};
    return ea * eb;
  endfunction

endpackage

FILE: design/prle_front.sv
// Front end: accepts pixels, tracks the open run and frame count, posts run commands.
module prle_front import prle_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                pixel_valid,
  input  logic [VALUE_W-1:0]  pixel_value,
  input  logic                queue_full,
  input  logic [LENGTH_W-1:0] frame_size,
  output logic                accept,
  output logic                push,
  output cmd_t                cmd
);

  logic [VALUE_W-1:0]  open_value;
  logic [LENGTH_W-1:0] open_length;
  logic [COUNT_W-1:0]  pixels_seen;

  logic [VALUE_W-1:0]  open_value_next;
  logic [LENGTH_W-1:0] open_length_next;
  logic [LENGTH_W-1:0] count;
  logic                flush;
  logic                closing;

  assign accept = pixel_valid && !queue_full;

  always_comb begin
    flush = 1'b0;
    if (open_length == '0) begin
      open_value_next  = pixel_value;
      open_length_next = LENGTH_W'(1);
    end else if (pixel_value == open_value) begin
      open_value_next  = open_value;
      open_length_next = open_length + LENGTH_W'(1);
    end else begin
      flush            = 1'b1;
      open_value_next  = pixel_value;
      open_length_next = LENGTH_W'(1);
    end
    count   = {1'b0, pixels_seen} + LENGTH_W'(1);
    closing = (count >= frame_size);
  end

  assign push              = accept && (flush || closing);
  assign cmd.flush         = flush;
  assign cmd.prev.length   = open_length;
  assign cmd.prev.value    = open_value;
  assign cmd.closing       = closing;
  assign cmd.last.length   = open_length_next;
  assign cmd.last.value    = open_value_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_value  <= '0;
      open_length <= '0;
      pixels_seen <= '0;
    end else if (accept) begin
      if (closing) begin
        open_value  <= '0;
        open_length <= '0;
        pixels_seen <= '0;
      end else begin
        open_value  <= open_value_next;
        open_length <= open_length_next;
        pixels_seen <= count[COUNT_W-1:0];
      end
    end
  end

endmodule

FILE: design/prle_queue.sv
// Short command queue between the front end and the output sequencer.
module prle_queue import prle_pkg::*; #(
  parameter int DEPTH = PRLE_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wdata,
  input  logic pop,
  output cmd_t rdata,
  output logic full,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t              entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;

  logic do_push;
  logic do_pop;

  assign full    = (fill == FULL_CNT);
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

FILE: design/prle_back.sv
// Back end: drains run commands into the registered result port, one run per cycle while run_stall is low.
module prle_back import prle_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                head,
  input  logic                head_valid,
  output logic                pop,
  output logic                run_valid,
  input  logic                run_stall,
  output logic [LENGTH_W-1:0] run_length,
  output logic [VALUE_W-1:0]  run_value,
  output logic                frame_end
);

  logic load;
  logic phase;       // high once the flushed run of a two-run entry has gone out
  logic send_prev;

  assign load      = !run_valid || !run_stall;
  assign send_prev = head.flush && !phase;
  assign pop       = load && head_valid && !(send_prev && head.closing);

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (load) begin
      run_valid <= head_valid;
      if (head_valid) begin
        phase <= send_prev && head.closing;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      if (send_prev) begin
        run_length <= head.prev.length;
        run_value  <= head.prev.value;
        frame_end  <= 1'b0;
      end else begin
        run_length <= head.last.length;
        run_value  <= head.last.value;
        frame_end  <= 1'b1;
      end
    end
  end

endmodule

FILE: design/pixel_run_length_encoder.sv
// Top level of the pixel run-length encoder: register port, front end, queue, back end.
//
// Pixels enter on pixel_value with pixel_valid; a request is taken at a clock edge
// where pixel_valid is high and pixel_stall is low. Runs leave on run_length,
// run_value and frame_end with run_valid, taken when run_stall is low.
// One pixel is accepted every cycle while pixel_stall is low. A result passes the
// command queue and the output register after the pixel that closes its run. The last
// pixel of a frame may close two runs; those leave one after the other, so the output
// side sets the sustained rate of one run per cycle while run_stall is low, and the
// small command queue absorbs the extra run. When the receiver stalls, the held result
// stays put, the queue fills and then pixel_stall rises until space frees up.
// row_total (byte address 0) and column_total (byte address 4) are written over
// the APB port, by the user only while the block is idle (unenforced); the frame size
// is multiplied out at the write. Only pwdata bits 12:0 are kept; values of 0 act as 1,
// values above 4096 act as 4096. Synchronous reset sets both registers to 1, empties
// the queue and the output stage, and clears the open run and pixel count.
module pixel_run_length_encoder import prle_pkg::*; #(
  parameter int QUEUE_DEPTH = PRLE_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  input  logic                pixel_valid,
  output logic                pixel_stall,
  input  logic [VALUE_W-1:0]  pixel_value,
  output logic                run_valid,
  input  logic                run_stall,
  output logic [LENGTH_W-1:0] run_length,
  output logic [VALUE_W-1:0]  run_value,
  output logic                frame_end
);

  logic [SIDE_W-1:0]   row_total;
  logic [SIDE_W-1:0]   column_total;
  logic [LENGTH_W-1:0] frame_size;
  logic                cfg_write;
  logic [SIDE_W-1:0]   wr_side;

  logic accept;
  logic push;
  logic pop;
  cmd_t cmd;
  cmd_t head;
  logic queue_full;
  logic queue_empty;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign wr_side   = pwdata[SIDE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      row_total    <= SIDE_W'(1);
      column_total <= SIDE_W'(1);
      frame_size   <= LENGTH_W'(1);
    end else if (cfg_write) begin
      case (paddr[2])
        REG_ROW_TOTAL: begin
          row_total  <= wr_side;
          frame_size <= frame_product(wr_side, column_total);
        end
        REG_COLUMN_TOTAL: begin
          column_total <= wr_side;
          frame_size   <= frame_product(row_total, wr_side);
        end
        default: begin
          row_total <= row_total;
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ROW_TOTAL:    prdata = {{(DATA_W-SIDE_W){1'b0}}, row_total};
      REG_COLUMN_TOTAL: prdata = {{(DATA_W-SIDE_W){1'b0}}, column_total};
      default:          prdata = '0;
    endcase
  end

  assign pixel_stall = queue_full;

  prle_front u_front (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_value (pixel_value),
    .queue_full  (queue_full),
    .frame_size  (frame_size),
    .accept      (accept),
    .push        (push),
    .cmd         (cmd)
  );

  prle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push && accept),
    .wdata (cmd),
    .pop   (pop),
    .rdata (head),
    .full  (queue_full),
    .empty (queue_empty)
  );

  prle_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (!queue_empty),
    .pop        (pop),
    .run_valid  (run_valid),
    .run_stall  (run_stall),
    .run_length (run_length),
    .run_value  (run_value),
    .frame_end  (frame_end)
  );

endmodule
